>>> hw/rtl/imufp_pkg.sv
// Shared types, constants and field helpers for the inertial sensor frame parser.
// Used by the byte cell, the record decoder, the top level and the checker.
package imufp_pkg;

  localparam int unsigned KeptLen = 10;  // packet bytes held: header .. last data byte
  localparam int unsigned NumVals = 7;   // values in one record
  localparam int unsigned CntW    = 4;   // byte count width, holds 0 .. KeptLen
  localparam int unsigned KindW   = 4;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] KindFirst = 8'h50;
  localparam logic [7:0] KindLast  = 8'h59;

  localparam logic [CntW-1:0] CntIdle = '0;
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntFull = CntW'(KeptLen);

  // Record kinds (type byte minus KindFirst)
  localparam logic [KindW-1:0] KindTime   = 4'd0;
  localparam logic [KindW-1:0] KindAcc    = 4'd1;
  localparam logic [KindW-1:0] KindGyro   = 4'd2;
  localparam logic [KindW-1:0] KindAngle  = 4'd3;
  localparam logic [KindW-1:0] KindMag    = 4'd4;
  localparam logic [KindW-1:0] KindPort   = 4'd5;
  localparam logic [KindW-1:0] KindPress  = 4'd6;
  localparam logic [KindW-1:0] KindLonLat = 4'd7;
  localparam logic [KindW-1:0] KindGpsSpd = 4'd8;
  localparam logic [KindW-1:0] KindQuat   = 4'd9;

  typedef logic [7:0] byte_t;
  typedef byte_t [KeptLen-1:0] frame_t;  // index i is packet byte i
  typedef logic signed [31:0] val_t;

  typedef struct packed {
    logic [KindW-1:0]     kind;
    val_t [NumVals-1:0]   vals;
  } rec_t;

  function automatic val_t be_u8(input byte_t b);
    return val_t'({24'h000000, b});
  endfunction

  function automatic val_t be_u16(input byte_t hi, input byte_t lo);
    return val_t'({16'h0000, hi, lo});
  endfunction

  function automatic val_t be_s16(input byte_t hi, input byte_t lo);
    return val_t'({{16{hi[7]}}, hi, lo});
  endfunction

  function automatic val_t be_s32(input byte_t b0, input byte_t b1,
                                  input byte_t b2, input byte_t b3);
    return val_t'({b0, b1, b2, b3});
  endfunction

endpackage

>>> hw/rtl/imufp_byte_cell.sv
// One cell of the packet byte shift line: holds one byte, loads from its neighbor.
// Depends on imufp_pkg for the byte type.
module imufp_byte_cell
  import imufp_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  byte_t data_i,
  output byte_t data_o
);

  byte_t data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/imufp_decode.sv
// Record decoder: maps the ten held packet bytes to a kind and seven values.
// Depends on imufp_pkg for frame and record types and field helpers.
module imufp_decode
  import imufp_pkg::*;
(
  input  frame_t frame_i,
  output logic   hit_o,
  output rec_t   rec_o
);

  byte_t            off;
  logic [KindW-1:0] kind;

  assign off   = frame_i[1] - KindFirst;
  assign kind  = off[KindW-1:0];
  assign hit_o = (frame_i[1] >= KindFirst) && (frame_i[1] <= KindLast);

  always_comb begin
    rec_o.kind = kind;
    rec_o.vals = '0;
    unique case (kind) inside
      KindTime: begin
        rec_o.vals[0] = be_u8(frame_i[2]);
        rec_o.vals[1] = be_u8(frame_i[3]);
        rec_o.vals[2] = be_u8(frame_i[4]);
        rec_o.vals[3] = be_u8(frame_i[5]);
        rec_o.vals[4] = be_u8(frame_i[6]);
        rec_o.vals[5] = be_u8(frame_i[7]);
        rec_o.vals[6] = be_u16(frame_i[8], frame_i[9]);
      end
      KindAcc, KindGyro, KindAngle, KindMag: begin
        rec_o.vals[0] = be_s16(frame_i[2], frame_i[3]);
        rec_o.vals[1] = be_s16(frame_i[4], frame_i[5]);
        rec_o.vals[2] = be_s16(frame_i[6], frame_i[7]);
      end
      KindPort: begin
        rec_o.vals[0] = be_u8(frame_i[2]);
        rec_o.vals[1] = be_u8(frame_i[3]);
        rec_o.vals[2] = be_u8(frame_i[4]);
        rec_o.vals[3] = be_u8(frame_i[5]);
      end
      KindPress, KindLonLat: begin
        rec_o.vals[0] = be_s32(frame_i[2], frame_i[3], frame_i[4], frame_i[5]);
        rec_o.vals[1] = be_s32(frame_i[6], frame_i[7], frame_i[8], frame_i[9]);
      end
      KindGpsSpd: begin
        rec_o.vals[0] = be_s16(frame_i[2], frame_i[3]);
        rec_o.vals[1] = be_s16(frame_i[4], frame_i[5]);
        rec_o.vals[2] = be_s32(frame_i[6], frame_i[7], frame_i[8], frame_i[9]);
      end
      KindQuat: begin
        rec_o.vals[0] = be_s16(frame_i[2], frame_i[3]);
        rec_o.vals[1] = be_s16(frame_i[4], frame_i[5]);
        rec_o.vals[2] = be_s16(frame_i[6], frame_i[7]);
        rec_o.vals[3] = be_s16(frame_i[8], frame_i[9]);
      end
      default: begin
        rec_o.vals = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/imu_frame_parser_core.sv
// Top level of the inertial sensor serial frame parser.
// Depends on imufp_pkg, imufp_byte_cell and imufp_decode.

// The parser takes one received serial byte per word on the rx channel and
// frames 11-byte packets that open with the header 0x55; while searching, any
// other byte is dropped. Packet bytes 0..9 move through a row of ten byte
// cells that shift once for every kept byte, so after the tenth byte the row
// holds the whole packet apart from the checksum. The eleventh byte (checksum,
// not checked) closes the packet: the type byte 0x50..0x59 is decoded in the
// same cycle and one record (kind plus seven big-endian values, unused ones
// zero) is loaded into the output register; any other type ends the packet
// silently. The parser accepts a byte in every cycle; the only stall is a
// closing byte that arrives while the output register still holds a record
// the consumer has not taken. A record appears on the out channel the cycle
// after its closing byte is accepted.
module imu_frame_parser_core
  import imufp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  frame_kind_o,
  output logic signed [31:0] value_zero_o,
  output logic signed [31:0] value_one_o,
  output logic signed [31:0] value_two_o,
  output logic signed [31:0] value_three_o,
  output logic signed [31:0] value_four_o,
  output logic signed [31:0] value_five_o,
  output logic signed [31:0] value_six_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  rec_t            rec_q;

  logic   rx_fire;
  logic   searching;
  logic   closing;
  logic   shift_en;
  logic   dec_hit;
  rec_t   dec_rec;
  byte_t  cell_q [KeptLen];
  frame_t frame;

  assign searching = (cnt_q == CntIdle);
  assign closing   = (cnt_q == CntFull);

  // Hold a closing byte back only while an untaken record sits in the output.
  assign rx_ready_o = !closing || !out_valid_q || out_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  // Advance the byte row on the header and on every data byte before the checksum.
  assign shift_en = rx_fire && !closing && (!searching || (rx_byte_i == HdrByte));

  for (genvar k = 0; k < KeptLen; k++) begin : g_cell
    byte_t cell_in;
    if (k == 0) begin : g_head
      assign cell_in = rx_byte_i;
    end else begin : g_link
      assign cell_in = cell_q[k-1];
    end
    imufp_byte_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_en),
      .data_i  (cell_in),
      .data_o  (cell_q[k])
    );
    // Oldest byte sits at the far end of the row.
    assign frame[KeptLen-1-k] = cell_q[k];
  end

  imufp_decode u_decode (
    .frame_i (frame),
    .hit_o   (dec_hit),
    .rec_o   (dec_rec)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (rx_fire) begin
      if (searching) begin
        if (rx_byte_i == HdrByte) begin
          cnt_d = CntOne;
        end
      end else if (closing) begin
        cnt_d = CntIdle;
      end else begin
        cnt_d = cnt_q + CntOne;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (rx_fire && closing && dec_hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CntIdle;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the record register only when a decoded packet closes.
  always_ff @(posedge clk_i) begin
    if (rx_fire && closing && dec_hit) begin
      rec_q <= dec_rec;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_kind_o  = rec_q.kind;
  assign value_zero_o  = rec_q.vals[0];
  assign value_one_o   = rec_q.vals[1];
  assign value_two_o   = rec_q.vals[2];
  assign value_three_o = rec_q.vals[3];
  assign value_four_o  = rec_q.vals[4];
  assign value_five_o  = rec_q.vals[5];
  assign value_six_o   = rec_q.vals[6];

endmodule

>>> hw/rtl/imufp_checker.sv
// Port-level checker for the frame parser, bound to imu_frame_parser_core.
// Depends on imufp_pkg for record kind codes.
module imufp_checker
  import imufp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  frame_kind_o,
  input logic signed [31:0] value_zero_o,
  input logic signed [31:0] value_three_o,
  input logic signed [31:0] value_four_o,
  input logic signed [31:0] value_five_o,
  input logic signed [31:0] value_six_o
);

  // A stalled record holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_kind_o)
      && $stable(value_zero_o) && $stable(value_six_o))
    else $error("stalled record changed");

  // A new record follows an accepted byte in the cycle before.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rx_valid_i && rx_ready_o))
    else $error("record without an accepted byte");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_kind_o <= KindQuat)
    else $error("record kind out of range");

  // Only time records use the three last values; besides them, only four-value kinds use the fourth.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_kind_o != KindTime) |->
      value_four_o == 0 && value_five_o == 0 && value_six_o == 0
      && (value_three_o == 0 || frame_kind_o == KindPort || frame_kind_o == KindQuat))
    else $error("unused value not zero");

  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_kind_o == KindTime || frame_kind_o == KindPort) |->
      value_zero_o[31:8] == 24'h000000)
    else $error("byte field wider than a byte");

endmodule

bind imu_frame_parser_core imufp_checker u_imufp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_valid_i),
  .rx_ready_o    (rx_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .frame_kind_o  (frame_kind_o),
  .value_zero_o  (value_zero_o),
  .value_three_o (value_three_o),
  .value_four_o  (value_four_o),
  .value_five_o  (value_five_o),
  .value_six_o   (value_six_o)
);

>>> tb/tb.sv
// Self-checking bench for imu_frame_parser_core: serial words in, decoded sensor records out.
// Depends on imufp_pkg and the parser RTL; holds its own frame tracker to predict records.

module tb;
  import imufp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;  // cycles without any accepted word
  localparam int unsigned GapPct     = 15;    // chance that a word opens an idle burst
  localparam int unsigned HoldPct    = 10;    // chance that the consumer opens a stall burst

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Drive every input to a known value from time zero
  logic        rx_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_ready = 1'b0;
  logic        rx_ready;
  logic        out_valid;
  logic [3:0]  frame_kind;
  val_t        value_zero, value_one, value_two, value_three;
  val_t        value_four, value_five, value_six;

  bit          idle_en = 1'b1;  // random idling on both channels
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned packet_words = 0;  // words kept or closing a packet
  int unsigned records_seen = 0;

  // Frame tracker: mirrors the packet bytes and the byte count
  byte_t       pkt_bytes [KeptLen];
  int unsigned pkt_count = 0;
  rec_t        expected_records [$];

  string val_name [NumVals] = '{"value_zero", "value_one", "value_two", "value_three",
                                "value_four", "value_five", "value_six"};

  always #6 clk = ~clk;

  imu_frame_parser_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .rx_valid_i    (rx_valid),
    .rx_ready_o    (rx_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .frame_kind_o  (frame_kind),
    .value_zero_o  (value_zero),
    .value_one_o   (value_one),
    .value_two_o   (value_two),
    .value_three_o (value_three),
    .value_four_o  (value_four),
    .value_five_o  (value_five),
    .value_six_o   (value_six)
  );

  // ---------------------------------------------------------------------------
  // Record prediction
  // ---------------------------------------------------------------------------

  function automatic val_t sx16_at(int unsigned at);
    return {{16{pkt_bytes[at][7]}}, pkt_bytes[at], pkt_bytes[at+1]};
  endfunction

  function automatic val_t word32_at(int unsigned at);
    return {pkt_bytes[at], pkt_bytes[at+1], pkt_bytes[at+2], pkt_bytes[at+3]};
  endfunction

  // Build the record for the packet now held; the type byte is already known good
  function automatic rec_t decode_record();
    rec_t r;
    logic [KindW-1:0] k;
    r = '0;
    k = KindW'(pkt_bytes[1] - KindFirst);
    r.kind = k;
    case (k)
      KindTime: begin
        for (int i = 0; i < 6; i++) r.vals[i] = {24'h000000, pkt_bytes[2+i]};
        r.vals[6] = {16'h0000, pkt_bytes[8], pkt_bytes[9]};
      end
      KindAcc, KindGyro, KindAngle, KindMag: begin
        for (int i = 0; i < 3; i++) r.vals[i] = sx16_at(2 + 2*i);
      end
      KindPort: begin
        for (int i = 0; i < 4; i++) r.vals[i] = {24'h000000, pkt_bytes[2+i]};
      end
      KindPress, KindLonLat: begin
        r.vals[0] = word32_at(2);
        r.vals[1] = word32_at(6);
      end
      KindGpsSpd: begin
        r.vals[0] = sx16_at(2);
        r.vals[1] = sx16_at(4);
        r.vals[2] = word32_at(6);
      end
      default: begin
        for (int i = 0; i < 4; i++) r.vals[i] = sx16_at(2 + 2*i);
      end
    endcase
    return r;
  endfunction

  // Advance the tracker by one accepted word; queue a record when a known packet closes
  function automatic void track_rx_word(byte_t b);
    if (pkt_count == 0) begin
      // searching: drop anything but the header
      if (b == HdrByte) begin
        pkt_bytes[0] = b;
        pkt_count = 1;
        packet_words++;
      end
    end else if (pkt_count < KeptLen) begin
      // header value in here is plain data
      pkt_bytes[pkt_count] = b;
      pkt_count++;
      packet_words++;
    end else begin
      // checksum word closes the packet without being checked
      pkt_count = 0;
      packet_words++;
      if (pkt_bytes[1] >= KindFirst && pkt_bytes[1] <= KindLast)
        expected_records.push_back(decode_record());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------

  // Send one word; hold valid and payload until the parser takes it
  task automatic send_word(input byte_t b);
    if (idle_en && $urandom_range(0, 99) < GapPct) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    track_rx_word(b);
    words_sent++;
  endtask

  // Send a full packet: header, type, eight data words (d2..d9 from the top), checksum
  task automatic send_packet(input byte_t type_b, input logic [63:0] body, input byte_t csum);
    send_word(HdrByte);
    send_word(type_b);
    for (int i = 0; i < 8; i++) send_word(body[63 - 8*i -: 8]);
    send_word(csum);
  endtask

  // Bias data toward sign edges and the header value
  function automatic byte_t pick_data_word();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return HdrByte;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] pick_body();
    logic [63:0] body;
    for (int i = 0; i < 8; i++) body[8*i +: 8] = pick_data_word();
    return body;
  endfunction

  function automatic byte_t pick_known_type();
    return byte_t'(KindFirst + $urandom_range(0, 9));
  endfunction

  // ---------------------------------------------------------------------------
  // Consumer, checker, watchdog
  // ---------------------------------------------------------------------------

  // Stall the out channel in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 99) < HoldPct) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted record with the oldest prediction, field by field
  always @(posedge clk) begin
    val_t got [NumVals];
    rec_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{value_zero, value_one, value_two, value_three,
              value_four, value_five, value_six};
      records_seen++;
      if (expected_records.size() == 0) begin
        report_mismatch("record with none predicted, frame_kind", 32'(frame_kind), '0);
      end else begin
        want = expected_records.pop_front();
        if (frame_kind !== want.kind)
          report_mismatch("frame_kind", 32'(frame_kind), 32'(want.kind));
        for (int i = 0; i < NumVals; i++)
          if (got[i] !== want.vals[i]) report_mismatch(val_name[i], got[i], want.vals[i]);
      end
    end
  end

  // End the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_valid && rx_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Timeout: no word moved for %0d cycles, %0d records pending",
                 StallLimit, expected_records.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A packet for every kind (two for time), with sign edges and all-ones / all-zeros data
  task automatic test_every_kind();
    send_packet(KindFirst + 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_packet(KindFirst + 8'd0, 64'h0001_0203_0405_8000, 8'hFF);
    send_packet(KindFirst + 8'd1, 64'h8000_7FFF_FFFF_0000, 8'h12);
    send_packet(KindFirst + 8'd2, 64'h0001_FFFE_8001_5555, 8'h00);
    send_packet(KindFirst + 8'd3, 64'h7FFF_8000_0000_FFFF, 8'hFF);
    send_packet(KindFirst + 8'd4, 64'hFFFF_FFFF_FFFF_FFFF, 8'hA5);
    send_packet(KindFirst + 8'd5, 64'hFF80_7F00_1234_5678, 8'h00);
    send_packet(KindFirst + 8'd6, 64'h8000_0000_7FFF_FFFF, 8'h3C);
    send_packet(KindFirst + 8'd7, 64'h7FFF_FFFF_8000_0000, 8'hFF);
    send_packet(KindFirst + 8'd8, 64'h8000_7FFF_FFFF_FFFF, 8'h00);
    send_packet(KindFirst + 8'd9, 64'h8000_7FFF_0000_FFFF, 8'h77);
  endtask

  // Drop non-header words while searching, then frame normally
  task automatic test_search_noise();
    send_word(8'h00);
    send_word(8'hFF);
    send_word(HdrByte - 8'd1);
    send_word(HdrByte + 8'd1);
    send_word(KindFirst + 8'd3);
    send_packet(KindFirst + 8'd1, 64'h1234_8765_0F0F_AAAA, 8'h00);
  endtask

  // Header value inside a packet is data, including in the checksum slot
  task automatic test_header_as_data();
    send_packet(KindFirst + 8'd3, {8{HdrByte}}, HdrByte);
    send_packet(KindFirst + 8'd2, 64'h5500_0055_5555_0000, 8'h00);
  endtask

  // Unknown type bytes close the packet with no record; the header value and KindLast as types give records
  task automatic test_unknown_types();
    send_packet(KindFirst - 8'd1, pick_body(), 8'h00);
    send_packet(KindLast + 8'd1, pick_body(), 8'hFF);
    send_packet(8'h00, pick_body(), 8'h00);
    send_packet(8'hFF, pick_body(), 8'h00);
    send_packet(HdrByte, pick_body(), 8'h00);
    send_packet(KindLast, pick_body(), 8'h00);
  endtask

  // Mostly well-formed packets with random content, plus noise and cut-short packets
  task automatic test_random_traffic(input int unsigned kept_goal);
    int unsigned goal;
    int unsigned pick;
    goal = packet_words + kept_goal;
    while (packet_words < goal) begin
      // toggle idling now and then so some stretches run without it
      if (idle_en && $urandom_range(0, 39) == 0) idle_en = 1'b0;
      else if (!idle_en && $urandom_range(0, 9) == 0) idle_en = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_packet(($urandom_range(0, 9) == 0) ? byte_t'($urandom_range(0, 255))
                                                : pick_known_type(),
                    pick_body(), byte_t'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 5)) send_word(byte_t'($urandom_range(0, 255)));
      end else begin
        // header plus a few words; the next words finish the packet as data
        send_word(HdrByte);
        repeat ($urandom_range(1, 9)) send_word(pick_data_word());
      end
    end
  endtask

  // Back-to-back packets with no idling on either side
  task automatic test_full_rate_tail();
    idle_en = 1'b0;
    repeat (18) send_packet(pick_known_type(), pick_body(), byte_t'($urandom_range(0, 255)));
    rx_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < KeptLen; i++) pkt_bytes[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_every_kind();
    test_search_noise();
    test_header_as_data();
    test_unknown_types();
    test_random_traffic(1500);
    test_full_rate_tail();

    // Drain outstanding records, then wait for stray output
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d serial words (%0d inside packets) and %0d records:", words_sent,
             packet_words, records_seen);
    $display("all ten kinds, unknown types, search noise, header as data, random stalls.");
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/imufp_pkg.sv
hw/rtl/imufp_byte_cell.sv
hw/rtl/imufp_decode.sv
hw/rtl/imu_frame_parser_core.sv
hw/rtl/imufp_checker.sv
tb/tb.sv
